@@ sv/assert_macros.svh @@
// Assertion macros used by the noise block RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define GNF_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("gnf assertion failed");
`define GNF_ASSERT_NORST(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("gnf assertion failed");
`else
`define GNF_ASSERT(lbl, clk, rst, prop)
`define GNF_ASSERT_NORST(lbl, clk, prop)
`endif
`endif

@@ sv/gnf_pkg.sv @@
// Types and constants of the fractal gradient noise block.
// No dependencies; used by gnf_cell, gnf_octave, the top level, the checker and the testbench.
`timescale 1ns / 1ps
package gnf_pkg;
   localparam logic [31:0] HASH_X    = 32'd374761393;
   localparam logic [31:0] HASH_Y    = 32'd668265263;
   localparam logic [31:0] HASH_Z    = 32'd1274126177;
   localparam logic [31:0] HASH_S    = 32'd2246822519;
   localparam logic [31:0] SEED_STEP = 32'd1013;

   localparam logic [1:0] CSR_SEED    = 2'd0;
   localparam logic [1:0] CSR_OCTAVES = 2'd1;

   localparam logic [30:0] RECIP_TAB [17] = '{
      31'd0, 31'd1073741824, 31'd357913941, 31'd153391689, 31'd71582788,
      31'd34636833, 31'd17043521, 31'd8454660, 31'd4210752, 31'd2101256,
      31'd1049601, 31'd524544, 31'd262208, 31'd131088, 31'd65540,
      31'd32769, 31'd16384};

   // Lattice index and Q0.16 fraction of each axis, plus the octave seed
   typedef struct packed {
      logic [2:0][31:0] idx;
      logic [2:0][15:0] frac;
      logic [31:0]      seed;
   } cell_type;
endpackage

@@ sv/gnf_cell.sv @@
// One octave cell of the coordinate chain: loads its own scaled point and
// seed, then hands the neighbour's contents down. Depends on gnf_pkg.
`timescale 1ns / 1ps
module gnf_cell #(
   parameter int STAGE = 0
) (
   input  logic                    clock,
   input  logic                    load,
   input  logic                    shift,
   input  logic signed [31:0]      pos_x,
   input  logic signed [31:0]      pos_y,
   input  logic signed [31:0]      pos_z,
   input  logic [31:0]             noise_seed,
   input  gnf_pkg::cell_type       next_cell,
   output gnf_pkg::cell_type       this_cell
);
   gnf_pkg::cell_type cell_ff, cell_in, load_val;
   logic [47:0] sx, sy, sz;

   always_comb begin
      sx = {{16{pos_x[31]}}, pos_x} << STAGE;
      sy = {{16{pos_y[31]}}, pos_y} << STAGE;
      sz = {{16{pos_z[31]}}, pos_z} << STAGE;
      load_val.idx[0]  = sx[47:16];
      load_val.idx[1]  = sy[47:16];
      load_val.idx[2]  = sz[47:16];
      load_val.frac[0] = sx[15:0];
      load_val.frac[1] = sy[15:0];
      load_val.frac[2] = sz[15:0];
      load_val.seed    = noise_seed + 32'(STAGE * 1013);
      if (load) begin
         cell_in = load_val;
      end else if (shift) begin
         cell_in = next_cell;
      end else begin
         cell_in = cell_ff;
      end
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
   end

   assign this_cell = cell_ff;
endmodule

@@ sv/gnf_octave.sv @@
// Pipelined single-octave evaluator: fade, corner hash, gradients, trilinear
// blend over six register stages. Depends on gnf_pkg.
`timescale 1ns / 1ps
module gnf_octave (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  gnf_pkg::cell_type        in_cell,
   output logic                     out_valid,
   output logic signed [19:0]       out_noise
);
   function automatic logic signed [19:0] grad(input logic [3:0] g,
         input logic signed [17:0] x, input logic signed [17:0] y,
         input logic signed [17:0] z);
      logic signed [19:0] u, v;
      u = (g < 4'd8) ? 20'(x) : 20'(y);
      if (g < 4'd4) begin
         v = 20'(y);
      end else if (g == 4'd12 || g == 4'd14) begin
         v = 20'(x);
      end else begin
         v = 20'(z);
      end
      if (g[0]) u = -u;
      if (g[1]) v = -v;
      return u + v;
   endfunction

   function automatic logic signed [19:0] blend(input logic signed [19:0] a,
         input logic signed [19:0] b, input logic [16:0] w);
      logic signed [20:0] d;
      logic signed [38:0] p;
      logic signed [22:0] sh;
      d  = 21'(b) - 21'(a);
      p  = 39'(d) * 39'(signed'({1'b0, w}));
      sh = signed'(p[38:16]);
      return 20'(23'(a) + sh);
   endfunction

   // stage 1
   logic             v1_ff;
   logic [2:0][15:0] t1_ff;
   logic [2:0][19:0] r1_ff, r1_in;
   logic [2:0][15:0] sq1_ff, sq1_in;
   logic [3:0][31:0] hp1_ff, hp1_in;
   // stage 2
   logic             v2_ff;
   logic [2:0][15:0] t2_ff;
   logic [2:0][19:0] s2_ff, s2_in;
   logic [2:0][15:0] cu2_ff, cu2_in;
   logic [31:0]      base2_ff, base2_in;
   // stage 3
   logic             v3_ff;
   logic [2:0][16:0] w3_ff, w3_in;
   logic signed [19:0] n3_ff [8];
   logic signed [19:0] n3_in [8];
   // stage 4..6
   logic             v4_ff, v5_ff, v6_ff;
   logic signed [19:0] x4_ff [4];
   logic signed [19:0] x4_in [4];
   logic [16:0]      w4_ff [2];
   logic signed [19:0] y5_ff [2];
   logic [16:0]      w5_ff;
   logic signed [19:0] z6_ff;

   always_comb begin
      logic [19:0] q;
      logic [35:0] tq;
      logic [31:0] tt;
      for (int k = 0; k < 3; k++) begin
         q  = 20'd983040 - 20'(20'd6 * 20'(in_cell.frac[k]));
         tq = 36'(in_cell.frac[k]) * 36'(q);
         tt = 32'(in_cell.frac[k]) * 32'(in_cell.frac[k]);
         r1_in[k]  = tq[35:16];
         sq1_in[k] = tt[31:16];
      end
      hp1_in[0] = in_cell.idx[0] * gnf_pkg::HASH_X;
      hp1_in[1] = in_cell.idx[1] * gnf_pkg::HASH_Y;
      hp1_in[2] = in_cell.idx[2] * gnf_pkg::HASH_Z;
      hp1_in[3] = in_cell.seed * gnf_pkg::HASH_S;
   end

   always_comb begin
      logic [31:0] ttt;
      for (int k = 0; k < 3; k++) begin
         s2_in[k]  = 20'd655360 - r1_ff[k];
         ttt       = 32'(sq1_ff[k]) * 32'(t1_ff[k]);
         cu2_in[k] = ttt[31:16];
      end
      base2_in = hp1_ff[0] + hp1_ff[1] + hp1_ff[2] + hp1_ff[3];
   end

   always_comb begin
      logic [35:0] f;
      logic [3:0]  h;
      logic signed [17:0] f0 [3];
      logic signed [17:0] f1 [3];
      for (int k = 0; k < 3; k++) begin
         f        = 36'(cu2_ff[k]) * 36'(s2_ff[k]);
         w3_in[k] = (f[35:16] > 20'd65536) ? 17'd65536 : f[32:16];
         f0[k]    = signed'({2'b00, t2_ff[k]});
         f1[k]    = signed'({2'b00, t2_ff[k]}) - 18'sd65536;
      end
      for (int c = 0; c < 8; c++) begin
         h = base2_ff[3:0] + (c[0] ? gnf_pkg::HASH_X[3:0] : 4'd0)
                           + (c[1] ? gnf_pkg::HASH_Y[3:0] : 4'd0)
                           + (c[2] ? gnf_pkg::HASH_Z[3:0] : 4'd0);
         n3_in[c] = grad(h, c[0] ? f1[0] : f0[0], c[1] ? f1[1] : f0[1],
                         c[2] ? f1[2] : f0[2]);
      end
   end

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         x4_in[j] = blend(n3_ff[2*j], n3_ff[2*j+1], w3_ff[0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      t1_ff    <= in_cell.frac;
      r1_ff    <= r1_in;
      sq1_ff   <= sq1_in;
      hp1_ff   <= hp1_in;
      t2_ff    <= t1_ff;
      s2_ff    <= s2_in;
      cu2_ff   <= cu2_in;
      base2_ff <= base2_in;
      w3_ff    <= w3_in;
      n3_ff    <= n3_in;
      x4_ff    <= x4_in;
      w4_ff[0] <= w3_ff[1];
      w4_ff[1] <= w3_ff[2];
      y5_ff[0] <= blend(x4_ff[0], x4_ff[1], w4_ff[0]);
      y5_ff[1] <= blend(x4_ff[2], x4_ff[3], w4_ff[0]);
      w5_ff    <= w4_ff[1];
      z6_ff    <= blend(y5_ff[0], y5_ff[1], w5_ff);
   end

   assign out_valid = v6_ff;
   assign out_noise = z6_ff;
endmodule

@@ sv/gradient_noise_fbm_3d.sv @@
// Top level of the fractal 3D gradient noise block: octave cell chain,
// shared octave pipeline, accumulator and normaliser. Depends on gnf_pkg,
// gnf_cell, gnf_octave and assert_macros.svh.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | req_pos_x, req_pos_y, req_pos_z
//   rsp     | out       | rsp_valid/rsp_stall | rsp_noise_value
//   csr     | in        | csr_write_en        | csr_index, csr_write_data
//
// One transaction at a time. With N octaves in effect (1 to MAX_OCTAVES) the
// octaves are issued from the head of the cell chain into the octave pipeline
// and accumulated as they leave it; after the last one the block leaves the
// run state, forms the partial products, rounds and loads the output register.
// Zero octaves go straight on to the partial products. The input stalls from
// acceptance until the result is loaded.
// Synchronous active-high reset clears the control state, the accumulator, the
// valid bits and the CSRs; the data registers are not reset.
// A stalled result holds in the output register; a finished point behind it
// holds in the last state and the input stays stalled until it moves.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gradient_noise_fbm_3d #(
   parameter int MAX_OCTAVES = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_noise_value,
   input  logic               csr_write_en,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_write_data
);
   localparam int CNT_W = $clog2(MAX_OCTAVES + 1);
   localparam int SW    = 20 + MAX_OCTAVES;
   localparam int MH_W  = SW - 18;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_RUN  = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_RND  = 3'd3;
   localparam logic [2:0] ST_FIN  = 3'd4;

   logic [31:0]  seed_ff;
   logic [3:0]   octaves_ff;
   logic [2:0]   state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, issue_ff, recv_ff, cnt_eff;
   logic signed [SW-1:0] acc_ff;
   logic [48:0]  pl_ff;
   logic [MH_W+30:0] ph_ff;
   logic         neg_ff;
   logic signed [15:0] res_ff;
   logic         rsp_valid_ff;
   logic signed [15:0] rsp_data_ff;

   logic         accept, issue, load;
   logic         ev_valid;
   logic signed [19:0] ev_noise;
   gnf_pkg::cell_type chain [MAX_OCTAVES+1];

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign load      = accept;
   assign issue     = (state_ff == ST_RUN) && (issue_ff != '0);
   assign cnt_eff   = (5'(octaves_ff) > 5'(MAX_OCTAVES)) ? CNT_W'(MAX_OCTAVES)
                                                        : CNT_W'(octaves_ff);

   // configuration: writes to unknown indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff    <= '0;
         octaves_ff <= 4'd3;
      end else if (csr_write_en) begin
         unique case (csr_index)
            gnf_pkg::CSR_SEED:    seed_ff    <= csr_write_data;
            gnf_pkg::CSR_OCTAVES: octaves_ff <= csr_write_data[3:0];
            default: ;
         endcase
      end
   end

   // octave cell chain: cell k holds octave k, advance towards cell 0
   assign chain[MAX_OCTAVES] = '0;
   for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_cell
      gnf_cell #(.STAGE(k)) u_cell (
         .clock      (clock),
         .load       (load),
         .shift      (issue),
         .pos_x      (req_pos_x),
         .pos_y      (req_pos_y),
         .pos_z      (req_pos_z),
         .noise_seed (seed_ff),
         .next_cell  (chain[k+1]),
         .this_cell  (chain[k])
      );
   end

   gnf_octave u_octave (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (issue),
      .in_cell   (chain[0]),
      .out_valid (ev_valid),
      .out_noise (ev_noise)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = ST_RUN;
         ST_RUN:  if (recv_ff == '0) state_in = ST_MUL;
         ST_MUL:  state_in = ST_RND;
         ST_RND:  state_in = ST_FIN;
         ST_FIN:  if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issue_ff     <= '0;
         recv_ff      <= '0;
         cnt_ff       <= '0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            cnt_ff   <= cnt_eff;
            issue_ff <= cnt_eff;
            recv_ff  <= cnt_eff;
            acc_ff   <= '0;
         end else begin
            if (issue) issue_ff <= issue_ff - 1'b1;
            if (ev_valid) begin
               // Horner form: earlier octaves end up with the larger weight
               acc_ff  <= (acc_ff <<< 1) + SW'(ev_noise);
               recv_ff <= recv_ff - 1'b1;
            end
         end
         if (state_ff == ST_FIN && (!rsp_valid_ff || !rsp_stall)) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // normalise: |S| * R[N], split into two partial products
   always_ff @(posedge clock) begin
      logic [SW-1:0] mag;
      logic [79:0]   tot;
      logic [47:0]   q;
      logic [16:0]   qc;
      mag = acc_ff[SW-1] ? SW'(-acc_ff) : SW'(acc_ff);
      if (state_ff == ST_MUL) begin
         pl_ff  <= 49'(mag[17:0]) * 49'(gnf_pkg::RECIP_TAB[5'(cnt_ff)]);
         ph_ff  <= (MH_W+31)'(mag[SW-1:18]) * (MH_W+31)'(gnf_pkg::RECIP_TAB[5'(cnt_ff)]);
         neg_ff <= acc_ff[SW-1];
      end
      tot = (80'(ph_ff) << 18) + 80'(pl_ff) + (80'd1 << 31);
      q   = tot[79:32];
      qc  = (q > 48'd32768) ? 17'd32768 : q[16:0];
      if (state_ff == ST_RND) begin
         if (neg_ff) begin
            res_ff <= 16'(-signed'({1'b0, qc}));
         end else begin
            res_ff <= (qc > 17'd32767) ? 16'sd32767 : signed'(qc[15:0]);
         end
      end
      if (state_ff == ST_FIN && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_data_ff <= res_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_noise_value = rsp_data_ff;

   `GNF_ASSERT(a_ev_only_run, clock, reset, ev_valid |-> (state_ff == ST_RUN))
   `GNF_ASSERT(a_issue_le_recv, clock, reset, (issue_ff <= recv_ff))
   `GNF_ASSERT(a_fin_delivers, clock, reset, ((state_ff == ST_FIN) && (!rsp_valid_ff || !rsp_stall)) |=> rsp_valid_ff)
endmodule

@@ verif/gnf_noise_checker.sv @@
// Checker for the fractal gradient noise block: mirrors the CSRs, predicts
// each noise sample and compares it with the result channel. Uses gnf_pkg.
`timescale 1ns / 1ps
module gnf_noise_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [15:0] rsp_noise_value,
   input  logic               csr_write_en,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_write_data,
   output int                 mismatches,
   output int                 outstanding
);
   localparam int OCTAVE_CAP = 8;

   logic [31:0]        seed_reg;
   logic [3:0]         octaves_reg;
   logic signed [15:0] noise_expected [$];

   function automatic longint unsigned fade_weight(longint unsigned t);
      longint unsigned q, r, s, t2, t3, f;
      q  = 64'd983040 - 64'd6 * t;
      r  = (t * q) >> 16;
      s  = 64'd655360 - r;
      t2 = (t * t) >> 16;
      t3 = (t2 * t) >> 16;
      f  = (t3 * s) >> 16;
      if (f > 64'd65536) f = 64'd65536;
      return f;
   endfunction

   function automatic longint blend_q16(longint a, longint b, longint w);
      longint d;
      d = (b - a) * w;
      return a + (d >>> 16);
   endfunction

   function automatic longint grad_dot(logic [31:0] h, longint x, longint y, longint z);
      logic [3:0] g;
      longint u, v;
      g = h[3:0];
      u = (g < 8) ? x : y;
      v = (g < 4) ? y : ((g == 12 || g == 14) ? x : z);
      return (g[0] ? -u : u) + (g[1] ? -v : v);
   endfunction

   function automatic longint octave_value(longint px, longint py, longint pz,
                                           int sh, logic [31:0] seed);
      logic [63:0] pv [3];
      logic [63:0] s;
      logic [31:0] lat_idx [3];
      logic [31:0] cx, cy, cz, h;
      longint f0 [3], f1 [3], w [3], n [8];
      longint x00, x10, x01, x11, y0, y1;
      pv[0] = px;
      pv[1] = py;
      pv[2] = pz;
      for (int k = 0; k < 3; k++) begin
         s          = pv[k] << sh;
         lat_idx[k] = s[47:16];
         f0[k]      = longint'({48'd0, s[15:0]});
         f1[k]      = f0[k] - 65536;
         w[k]       = longint'(fade_weight({48'd0, s[15:0]}));
      end
      for (int k = 0; k < 8; k++) begin
         cx   = lat_idx[0] + 32'(k & 1);
         cy   = lat_idx[1] + 32'((k >> 1) & 1);
         cz   = lat_idx[2] + 32'((k >> 2) & 1);
         h    = cx * gnf_pkg::HASH_X + cy * gnf_pkg::HASH_Y + cz * gnf_pkg::HASH_Z
                + seed * gnf_pkg::HASH_S;
         n[k] = grad_dot(h, (k & 1) ? f1[0] : f0[0], ((k >> 1) & 1) ? f1[1] : f0[1],
                         ((k >> 2) & 1) ? f1[2] : f0[2]);
      end
      x00 = blend_q16(n[0], n[1], w[0]);
      x10 = blend_q16(n[2], n[3], w[0]);
      x01 = blend_q16(n[4], n[5], w[0]);
      x11 = blend_q16(n[6], n[7], w[0]);
      y0  = blend_q16(x00, x10, w[1]);
      y1  = blend_q16(x01, x11, w[1]);
      return blend_q16(y0, y1, w[2]);
   endfunction

   function automatic logic signed [15:0] predict_noise(logic signed [31:0] x,
                                                        logic signed [31:0] y,
                                                        logic signed [31:0] z);
      int              cnt;
      longint          sum, res;
      longint unsigned mag, q;
      logic [31:0]     oct_seed;
      cnt = octaves_reg;
      sum = 0;
      if (cnt == 0) return '0;
      if (cnt > OCTAVE_CAP) cnt = OCTAVE_CAP;
      for (int i = 0; i < cnt; i++) begin
         oct_seed = seed_reg + 32'(i) * gnf_pkg::SEED_STEP;
         sum += octave_value(longint'(x), longint'(y), longint'(z), i, oct_seed)
                * (longint'(1) << (cnt - 1 - i));
      end
      mag = (sum < 0) ? -sum : sum;
      q   = (mag * {33'd0, gnf_pkg::RECIP_TAB[cnt]} + 64'h8000_0000) >> 32;
      if (q > 64'd32768) q = 64'd32768;
      res = (sum < 0) ? -longint'(q) : longint'(q);
      if (res > 32767) res = 32767;
      return res[15:0];
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         seed_reg    <= '0;
         octaves_reg <= 4'd3;
         noise_expected.delete();
         mismatches = 0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               gnf_pkg::CSR_SEED:    seed_reg    <= csr_write_data;
               gnf_pkg::CSR_OCTAVES: octaves_reg <= csr_write_data[3:0];
               default:     ;
            endcase
         end
         if (req_valid && !req_stall)
            noise_expected = {noise_expected,
                              predict_noise(req_pos_x, req_pos_y, req_pos_z)};
         if (rsp_valid && !rsp_stall) begin
            if (noise_expected.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected noise result %0d", rsp_noise_value);
            end else begin
               if (rsp_noise_value !== noise_expected[0]) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("noise mismatch: expected %0d, got %0d",
                              noise_expected[0], rsp_noise_value);
               end
               void'(noise_expected.pop_front());
            end
         end
      end
      outstanding = noise_expected.size();
   end
endmodule

@@ verif/gradient_noise_fbm_3d_test.sv @@
// Top of the noise block testbench: clock, reset, CSR writes, point stimulus
// and result back-pressure. Depends on gnf_pkg, gnf_noise_checker and the RTL.
`timescale 1ns / 1ps
module gradient_noise_fbm_3d_test;
   localparam int CYCLE_LIMIT = 400000;
   localparam int LONG_HOLD   = 300;
   localparam int SETTLE      = 40;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [31:0] req_pos_x = '0;
   logic signed [31:0] req_pos_y = '0;
   logic signed [31:0] req_pos_z = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [15:0] rsp_noise_value;
   logic               csr_write_en = 1'b0;
   logic [1:0]         csr_index = '0;
   logic [31:0]        csr_write_data = '0;

   int mismatches, outstanding;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_left = 0;
   bit hold_req = 0;
   int cycles = 0;

   gradient_noise_fbm_3d dut (.*);

   gnf_noise_checker checker_i (.*);

   always #2 clock = ~clock;

   // Abort a hung run
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Result-side back-pressure; a requested long hold takes priority
   always @(negedge clock) begin
      if (hold_req) begin
         hold_left = LONG_HOLD;
         hold_req  = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Offer one point; hold the payload until the block takes it.
   // Entered and left at a falling edge; valid stays high after a point unless the next call idles first.
   task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_pos_x <= x;
      req_pos_y <= y;
      req_pos_z <= z;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Drop valid and wait until every expected sample has come back
   task automatic drain;
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [31:0] data);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= data;
      @(negedge clock);
      csr_write_en   <= 1'b0;
      @(negedge clock);
   endtask

   // Mix of full-range words, points near the origin, bare fractions and points at the extremes
   function automatic logic [31:0] pick_coord();
      logic [31:0] v;
      case ($urandom_range(3))
         0: v = $urandom;
         1: v = $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
         2: v = $urandom_range(0, 32'hFFFF) | ($urandom_range(1) ? 32'hFFFF_0000 : 32'h0);
         default: v = $urandom_range(1) ? 32'h7FFF_0000 | $urandom_range(0, 32'hFFFF)
                                        : 32'h8000_0000 | $urandom_range(0, 32'hFFFF);
      endcase
      return v;
   endfunction

   task automatic random_points(int count);
      for (int i = 0; i < count; i++) send_point(pick_coord(), pick_coord(), pick_coord());
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: origin, extremes, fraction edges, lattice edges
      send_point(32'h0, 32'h0, 32'h0);
      send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_point(32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_FFFF);
      send_point(32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000);
      send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_point(32'h0001_8000, 32'hFFFE_8000, 32'h0002_8000);
      send_point(32'h7FFF_FFFF, 32'h0, 32'h8000_0000);
      send_point(32'hAAAA_AAAA, 32'h5555_5555, 32'hC3C3_3C3C);
      drain();

      // Most octaves with lattice wrap at the top bits, and a large seed
      write_csr(gnf_pkg::CSR_SEED, 32'hFFFF_FFFF);
      write_csr(gnf_pkg::CSR_OCTAVES, 32'd8);
      send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_8000);
      send_point(32'h0000_4000, 32'h0000_C000, 32'hFFFF_2000);
      send_point(32'h8000_0001, 32'h7FFF_0001, 32'h0000_0001);
      drain();

      // Zero octaves gives silence
      write_csr(gnf_pkg::CSR_OCTAVES, 32'd0);
      send_point(32'h0001_2345, 32'hFFF0_8000, 32'h7FFF_FFFF);
      send_point(32'h8000_0000, 32'h0, 32'h0000_FFFF);
      drain();

      // Above the octave cap acts as the cap; unknown indexes are ignored
      write_csr(gnf_pkg::CSR_SEED, 32'h0);
      write_csr(gnf_pkg::CSR_OCTAVES, 32'hFFFF_FFFF);
      write_csr(2'd2, 32'h1234_5678);
      write_csr(2'd3, 32'hFFFF_FFFF);
      send_point(32'h0003_7000, 32'hFFFC_1000, 32'h0000_9000);
      send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
      drain();

      // Single octave
      write_csr(gnf_pkg::CSR_OCTAVES, 32'd1);
      send_point(32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
      send_point(32'hFFFF_8000, 32'h0001_0000, 32'h7FFF_FFFF);
      drain();

      // Random part, sender light and receiver heavy first
      send_idle_pct = 25;
      recv_idle_pct = 59;
      write_csr(gnf_pkg::CSR_SEED, $urandom);
      write_csr(gnf_pkg::CSR_OCTAVES, $urandom_range(1, 8));
      random_points(100);
      drain();
      write_csr(gnf_pkg::CSR_SEED, $urandom);
      write_csr(gnf_pkg::CSR_OCTAVES, 32'd8);
      random_points(100);
      drain();

      // Then the other way round, with one long result hold-off to fill the block
      send_idle_pct = 59;
      recv_idle_pct = 25;
      write_csr(gnf_pkg::CSR_SEED, $urandom);
      write_csr(gnf_pkg::CSR_OCTAVES, 32'd1);
      hold_req = 1;
      random_points(100);
      drain();
      write_csr(gnf_pkg::CSR_SEED, $urandom);
      write_csr(gnf_pkg::CSR_OCTAVES, $urandom_range(9, 15));
      random_points(100);
      drain();

      // Flat out on both sides
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_csr(gnf_pkg::CSR_SEED, $urandom);
      write_csr(gnf_pkg::CSR_OCTAVES, $urandom_range(1, 8));
      random_points(100);
      drain();
      write_csr(gnf_pkg::CSR_SEED, 32'h0);
      write_csr(gnf_pkg::CSR_OCTAVES, $urandom_range(0, 15));
      random_points(100);
      drain();

      if (mismatches == 0 && outstanding == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
